/* design/rbcb_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and constants for the retry backoff circuit breaker
// no dependencies; every other design file refers to this package by scoped names
package rbcb_pkg;

    localparam int TIME_WIDTH_DEFAULT = 40;
    localparam int TIME_WIDTH_MIN     = 32;

    // input fields other than the timestamp: length, outcome, failed flag, code, response
    localparam int IN_FIXED_BITS = 28;
    localparam int OUT_DATA_W    = 32;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [31:0] RST_INITIAL_BACKOFF = 32'd100;
    localparam logic [31:0] RST_MAX_BACKOFF     = 32'd5000;
    localparam logic [7:0]  RST_RETRY_LIMIT     = 8'd3;
    localparam logic [31:0] RST_COOLDOWN        = 32'd1000;
    localparam logic [15:0] RST_CAPACITY        = 16'd260;
    localparam logic [15:0] DEFAULT_CAPACITY    = 16'd260;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_INITIAL_BACKOFF = 3'd0,
        CFG_MAX_BACKOFF     = 3'd1,
        CFG_RETRY_LIMIT     = 3'd2,
        CFG_COOLDOWN        = 3'd3,
        CFG_CAPACITY        = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_SUBMIT = 2'd0,
        KIND_STEP   = 2'd1,
        KIND_RESET  = 2'd2,
        KIND_TAKE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OUTCOME_ACCEPTED = 2'd0,
        OUTCOME_BUSY     = 2'd1,
        OUTCOME_FAILED   = 2'd2
    } outcome_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BUSY    = 3'd1,
        ST_INVALID = 3'd2,
        ST_NORES   = 3'd3,
        ST_FAIL    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SUP_IDLE    = 2'd0,
        SUP_WAITING = 2'd1,
        SUP_RETRY   = 2'd2,
        SUP_OPEN    = 2'd3
    } sup_state_t;

    localparam int EV_CLOSED  = 0;
    localparam int EV_ATTEMPT = 1;
    localparam int EV_RETRY   = 2;
    localparam int EV_GIVEUP  = 3;
    localparam int EV_OPEN    = 4;
    localparam int EV_RESP    = 5;
    localparam int EV_W       = 6;

    // configuration as the core sees it, limits already normalised
    typedef struct packed {
        logic [31:0] initial_backoff;
        logic [31:0] init_or_one;
        logic [31:0] backoff_cap;
        logic [7:0]  retry_limit;
        logic [31:0] cooldown;
        logic [15:0] capacity;
    } cfg_t;

    // result beat, last member in the lowest bits
    typedef struct packed {
        logic               response_taken;
        logic [8:0]         retries_done;
        sup_state_t         supervisor_state;
        logic               send_strobe;
        logic [EV_W-1:0]    event_mask;
        logic [7:0]         status_code;
        status_t            status;
    } res_t;

endpackage

/* design/rbcb_cfg.sv */
`timescale 1ns / 1ps
// configuration registers and normalisation of the backoff limits and capacity
// depends on rbcb_pkg
module rbcb_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rbcb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [rbcb_pkg::CFG_DATA_W-1:0]    cfg_data,
    output rbcb_pkg::cfg_t                     cfg
);

    logic [31:0] initial_backoff_reg;
    logic [31:0] max_backoff_reg;
    logic [7:0]  retry_limit_reg;
    logic [31:0] cooldown_reg;
    logic [15:0] capacity_reg;
    logic [31:0] max_or_init;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_backoff_reg <= rbcb_pkg::RST_INITIAL_BACKOFF;
            max_backoff_reg     <= rbcb_pkg::RST_MAX_BACKOFF;
            retry_limit_reg     <= rbcb_pkg::RST_RETRY_LIMIT;
            cooldown_reg        <= rbcb_pkg::RST_COOLDOWN;
            capacity_reg        <= rbcb_pkg::RST_CAPACITY;
        end
        else if (cfg_we)
        begin
            case (rbcb_pkg::cfg_idx_t'(cfg_addr))
                rbcb_pkg::CFG_INITIAL_BACKOFF: initial_backoff_reg <= cfg_data[31:0];
                rbcb_pkg::CFG_MAX_BACKOFF:     max_backoff_reg     <= cfg_data[31:0];
                rbcb_pkg::CFG_RETRY_LIMIT:     retry_limit_reg     <= cfg_data[7:0];
                rbcb_pkg::CFG_COOLDOWN:        cooldown_reg        <= cfg_data[31:0];
                rbcb_pkg::CFG_CAPACITY:        capacity_reg        <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.initial_backoff = initial_backoff_reg;
        cfg.init_or_one     = (initial_backoff_reg != 32'd0) ? initial_backoff_reg : 32'd1;
        // zero cap means the initial delay or one if that is zero, and the cap never sits below the initial delay
        max_or_init         = (max_backoff_reg != 32'd0) ? max_backoff_reg : cfg.init_or_one;
        cfg.backoff_cap     = (max_or_init < initial_backoff_reg) ? initial_backoff_reg
                                                                  : max_or_init;
        cfg.retry_limit     = retry_limit_reg;
        cfg.cooldown        = cooldown_reg;
        cfg.capacity        = (capacity_reg != 16'd0) ? capacity_reg
                                                      : rbcb_pkg::DEFAULT_CAPACITY;
    end

endmodule

/* design/rbcb_in_stage.sv */
`timescale 1ns / 1ps
// input register: holds one accepted beat until the core takes it
// depends on rbcb_pkg
module rbcb_in_stage #(
    parameter int TIME_WIDTH = rbcb_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [TIME_WIDTH+rbcb_pkg::IN_FIXED_BITS-1:0] s_item,
    input  logic [1:0]                                  s_kind,
    input  logic                                        advance,
    output logic                                        item_valid,
    output logic [TIME_WIDTH+rbcb_pkg::IN_FIXED_BITS-1:0] item,
    output logic [1:0]                                  item_kind
);

    logic                                          valid_reg;
    logic                                          valid_next;
    logic [TIME_WIDTH+rbcb_pkg::IN_FIXED_BITS-1:0] item_reg;
    logic [1:0]                                    kind_reg;
    logic                                          load;

    assign s_tready   = !valid_reg || advance;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= s_item;
            kind_reg <= s_kind;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
    assign item_kind  = kind_reg;

endmodule

/* design/rbcb_core.sv */
`timescale 1ns / 1ps
// supervisor state and the single-pass event logic: circuit, backoff and retry schedule
// depends on rbcb_pkg
module rbcb_core #(
    parameter int TIME_WIDTH = rbcb_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  rbcb_pkg::cfg_t                                cfg,
    input  logic                                          advance,
    input  logic [TIME_WIDTH+rbcb_pkg::IN_FIXED_BITS-1:0] item,
    input  logic [1:0]                                    item_kind,
    output rbcb_pkg::res_t                                res
);

    localparam int TW = TIME_WIDTH;

    typedef struct packed {
        logic          open;
        logic [TW-1:0] rel;
        logic          awaiting;
        logic          held;
        logic [8:0]    retry;
        logic [31:0]   backoff;
        logic [TW-1:0] due;
        logic          reply;
    } st_t;

    typedef struct packed {
        st_t                       s;
        logic [rbcb_pkg::EV_W-1:0] ev;
        logic                      strobe;
        rbcb_pkg::status_t         sts;
    } wk_t;

    st_t st_reg;
    st_t st_next;

    logic [TW-1:0] now;
    logic [15:0]   len;
    logic [1:0]    outcome;
    logic          efail;
    logic [7:0]    fcode;
    logic          resp;

    assign now     = item[TW-1:0];
    assign len     = item[TW+15:TW];
    assign outcome = item[TW+17:TW+16];
    assign efail   = item[TW+18];
    assign fcode   = item[TW+26:TW+19];
    assign resp    = item[TW+27];

    // saturating time sum
    function automatic logic [TW-1:0] tadd(input logic [TW-1:0] a, input logic [31:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {{(TW-31){1'b0}}, b};
        return s[TW] ? {TW{1'b1}} : s[TW-1:0];
    endfunction

    function automatic wk_t close_cb(input wk_t w);
        wk_t r;
        r = w;
        if (r.s.open)
        begin
            r.s.open = 1'b0;
            r.s.rel  = '0;
            r.ev[rbcb_pkg::EV_CLOSED] = 1'b1;
        end
        return r;
    endfunction

    function automatic wk_t open_cb(input wk_t w, input logic [TW-1:0] t);
        wk_t r;
        r = w;
        if (!r.s.open)
        begin
            r.s.open     = 1'b1;
            r.s.rel      = tadd(t, cfg.cooldown);
            r.s.awaiting = 1'b0;
            r.s.held     = 1'b0;
            r.s.due      = '0;
            r.ev[rbcb_pkg::EV_OPEN] = 1'b1;
        end
        return r;
    endfunction

    function automatic wk_t fail_retry(input wk_t w, input logic [TW-1:0] t);
        wk_t         r;
        logic [32:0] dbl;
        r   = w;
        dbl = {r.s.backoff, 1'b0};
        r.s.awaiting = 1'b0;
        if (r.s.retry != 9'h1FF)
        begin
            r.s.retry = r.s.retry + 9'd1;
        end
        if (r.s.retry > {1'b0, cfg.retry_limit})
        begin
            r.ev[rbcb_pkg::EV_GIVEUP] = 1'b1;
            r = open_cb(r, t);
        end
        else
        begin
            if (r.s.backoff == 32'd0)
            begin
                r.s.backoff = cfg.init_or_one;
            end
            else
            begin
                r.s.backoff = (dbl > {1'b0, cfg.backoff_cap}) ? cfg.backoff_cap : dbl[31:0];
            end
            r.s.due = tadd(t, r.s.backoff);
            r.ev[rbcb_pkg::EV_RETRY] = 1'b1;
        end
        return r;
    endfunction

    function automatic wk_t try_send(input wk_t w, input logic [TW-1:0] t,
                                     input logic [1:0] oc);
        wk_t r;
        r = w;
        if (!r.s.held || r.s.open || r.s.awaiting)
        begin
            r.sts = rbcb_pkg::ST_BUSY;
        end
        else
        begin
            r.strobe = 1'b1;
            case (rbcb_pkg::outcome_t'(oc))
                rbcb_pkg::OUTCOME_ACCEPTED:
                begin
                    r.s.awaiting = 1'b1;
                    r.s.due      = '0;
                    r.ev[rbcb_pkg::EV_ATTEMPT] = 1'b1;
                    r.sts        = rbcb_pkg::ST_OK;
                end
                rbcb_pkg::OUTCOME_BUSY:
                begin
                    // busy engine defers by the initial delay
                    r.s.due     = tadd(t, cfg.init_or_one);
                    r.s.backoff = cfg.init_or_one;
                    r.sts       = rbcb_pkg::ST_BUSY;
                end
                default:
                begin
                    r     = fail_retry(r, t);
                    r.sts = rbcb_pkg::ST_FAIL;
                end
            endcase
        end
        return r;
    endfunction

    wk_t               w;
    logic              aw0;
    logic              taken;
    logic [7:0]        code;
    rbcb_pkg::status_t sts_keep;

    always_comb
    begin
        w.s      = st_reg;
        w.ev     = '0;
        w.strobe = 1'b0;
        w.sts    = rbcb_pkg::ST_OK;
        code     = 8'd0;
        taken    = 1'b0;
        aw0      = st_reg.awaiting;
        sts_keep = rbcb_pkg::ST_OK;
        case (rbcb_pkg::kind_t'(item_kind))
            rbcb_pkg::KIND_SUBMIT:
            begin
                if (len == 16'd0)
                begin
                    w.sts = rbcb_pkg::ST_INVALID;
                end
                else
                begin
                    if (w.s.open)
                    begin
                        if (now >= w.s.rel)
                        begin
                            w = close_cb(w);
                        end
                        else
                        begin
                            w.sts = rbcb_pkg::ST_BUSY;
                        end
                    end
                    if (w.sts == rbcb_pkg::ST_OK)
                    begin
                        if (len > cfg.capacity)
                        begin
                            w.sts = rbcb_pkg::ST_NORES;
                        end
                        else
                        begin
                            w.s.held    = 1'b1;
                            w.s.retry   = 9'd0;
                            w.s.backoff = cfg.initial_backoff;
                            w.s.due     = '0;
                            w.s.reply   = 1'b0;
                            w = try_send(w, now, outcome);
                            if (w.sts == rbcb_pkg::ST_FAIL)
                            begin
                                code = fcode;
                            end
                        end
                    end
                end
            end
            rbcb_pkg::KIND_STEP:
            begin
                if (w.s.open && now >= w.s.rel)
                begin
                    w = close_cb(w);
                end
                if (aw0)
                begin
                    if (efail)
                    begin
                        w.sts = rbcb_pkg::ST_FAIL;
                        code  = fcode;
                        w = fail_retry(w, now);
                    end
                    if (!w.s.open && resp)
                    begin
                        w.s.awaiting = 1'b0;
                        w.s.held     = 1'b0;
                        w.s.reply    = 1'b1;
                        w.s.retry    = 9'd0;
                        w.s.backoff  = cfg.initial_backoff;
                        w.s.due      = '0;
                        w.ev[rbcb_pkg::EV_RESP] = 1'b1;
                    end
                end
                // a due retry goes out; the status stays as it was, so it shows in the strobe, the mask and the state
                if (!w.s.awaiting && w.s.held && !w.s.open && w.s.due != '0 && now >= w.s.due)
                begin
                    sts_keep = w.sts;
                    w = try_send(w, now, outcome);
                    w.sts = sts_keep;
                end
            end
            rbcb_pkg::KIND_RESET:
            begin
                w = close_cb(w);
                w.s.awaiting = 1'b0;
                w.s.retry    = 9'd0;
                w.s.backoff  = cfg.initial_backoff;
                w.s.due      = '0;
                w.s.reply    = 1'b0;
                w.s.held     = 1'b0;
            end
            default:
            begin
                if (w.s.reply)
                begin
                    w.s.reply = 1'b0;
                    taken     = 1'b1;
                end
            end
        endcase
        st_next = w.s;

        res.status         = w.sts;
        res.status_code    = code;
        res.event_mask     = w.ev;
        res.send_strobe    = w.strobe;
        res.retries_done   = w.s.retry;
        res.response_taken = taken;
        if (w.s.open)
        begin
            res.supervisor_state = rbcb_pkg::SUP_OPEN;
        end
        else if (w.s.awaiting)
        begin
            res.supervisor_state = rbcb_pkg::SUP_WAITING;
        end
        else if (w.s.held && w.s.due != '0)
        begin
            res.supervisor_state = rbcb_pkg::SUP_RETRY;
        end
        else if (w.s.held)
        begin
            res.supervisor_state = rbcb_pkg::SUP_WAITING;
        end
        else
        begin
            res.supervisor_state = rbcb_pkg::SUP_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.open     <= 1'b0;
            st_reg.rel      <= '0;
            st_reg.awaiting <= 1'b0;
            st_reg.held     <= 1'b0;
            st_reg.retry    <= 9'd0;
            st_reg.backoff  <= rbcb_pkg::RST_INITIAL_BACKOFF;
            st_reg.due      <= '0;
            st_reg.reply    <= 1'b0;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

endmodule

/* design/rbcb_out_stage.sv */
`timescale 1ns / 1ps
// result register on the master side, refilled in the same cycle it drains
// depends on rbcb_pkg
module rbcb_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  rbcb_pkg::res_t res,
    output logic           advance,
    output logic           m_tvalid,
    input  logic           m_tready,
    output rbcb_pkg::res_t m_res
);

    logic           valid_reg;
    logic           valid_next;
    rbcb_pkg::res_t res_reg;

    assign advance    = item_valid && (!valid_reg || m_tready);
    assign valid_next = advance || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

/* design/retry_backoff_circuit_breaker.sv */
`timescale 1ns / 1ps
// Retry supervisor with exponential backoff and a circuit breaker. One event beat
// (submit, step, reset or take) is accepted every clock cycle while the result register
// can drain, and each gives exactly one result beat: the beat is held in the input
// register, then makes one pass through the event logic into the result register, which
// presents it on the master side; the supervisor registers are rewritten once per event.
// s_tready stays high as long as the result register can drain; configuration is to be
// written through cfg_we/cfg_addr/cfg_data only while no beat is in flight, a rule for
// the user that the block itself does not enforce.
// depends on rbcb_pkg, rbcb_cfg, rbcb_in_stage, rbcb_core, rbcb_out_stage
module retry_backoff_circuit_breaker #(
    parameter int TIME_WIDTH = rbcb_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rbcb_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [rbcb_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // now_ms, length, send_outcome, engine_failed, failure_code, response_arrived
    input  logic [((TIME_WIDTH+rbcb_pkg::IN_FIXED_BITS+7)/8)*8-1:0] s_tdata,
    // kind
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // status, status_code, event_mask, send_strobe, supervisor_state, retries_done,
    // response_taken
    output logic [rbcb_pkg::OUT_DATA_W-1:0]      m_tdata
);

    localparam int ITEM_W = TIME_WIDTH + rbcb_pkg::IN_FIXED_BITS;
    localparam int RES_W  = $bits(rbcb_pkg::res_t);

    rbcb_pkg::cfg_t    cfg;
    logic              advance;
    logic              item_valid;
    logic [ITEM_W-1:0] item;
    logic [1:0]        item_kind;
    rbcb_pkg::res_t    res;
    rbcb_pkg::res_t    m_res;

    rbcb_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    rbcb_in_stage #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_tdata[ITEM_W-1:0]),
        .s_kind     (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item),
        .item_kind  (item_kind)
    );

    rbcb_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .advance   (advance),
        .item      (item),
        .item_kind (item_kind),
        .res       (res)
    );

    rbcb_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .res        (res),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_res      (m_res)
    );

    assign m_tdata = {{(rbcb_pkg::OUT_DATA_W-RES_W){1'b0}}, m_res};

endmodule

/* dv/rbcb_result_checker.sv */
`timescale 1ns / 1ps
// result checker for the retry backoff circuit breaker: keeps its own copy of the
// supervisor and configuration, predicts a result beat per event beat, compares in order
// depends on rbcb_pkg
module rbcb_result_checker #(
    parameter int TIME_WIDTH = rbcb_pkg::TIME_WIDTH_DEFAULT,
    parameter int IN_W       = ((TIME_WIDTH + rbcb_pkg::IN_FIXED_BITS + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rbcb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [rbcb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    // now_ms, length, send_outcome, engine_failed, failure_code, response_arrived
    input  logic [IN_W-1:0]                    s_tdata,
    // kind
    input  logic [1:0]                         s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // status, status_code, event_mask, send_strobe, supervisor_state, retries_done,
    // response_taken
    input  logic [rbcb_pkg::OUT_DATA_W-1:0]    m_tdata,
    output int unsigned                        outstanding,
    output int unsigned                        failures
);
    import rbcb_pkg::*;

    typedef logic [TIME_WIDTH-1:0] ms_t;
    localparam ms_t TIME_MAX = {TIME_WIDTH{1'b1}};

    // configuration as written
    logic [31:0] init_backoff;
    logic [31:0] max_backoff;
    logic [7:0]  retry_limit;
    logic [31:0] cool_period;
    logic [15:0] capacity;

    // supervisor copy
    logic        breaker_open;
    logic        awaiting;
    logic        held;
    logic        reply_ready;
    ms_t         release_at;
    ms_t         due_at;
    logic [15:0] attempts;
    logic [8:0]  retries;
    logic [31:0] backoff;

    logic [EV_W-1:0] ev_flags;
    logic            sent;

    res_t        predicted_results[$];
    res_t        want;
    res_t        got;
    int unsigned mismatches = 0;

    // normalised backoff limits
    wire [31:0] min_delay   = (init_backoff != 32'd0) ? init_backoff : 32'd1;
    wire [31:0] max_or_min  = (max_backoff != 32'd0) ? max_backoff : min_delay;
    wire [31:0] backoff_cap = (max_or_min < init_backoff) ? init_backoff : max_or_min;

    function automatic ms_t sat_add(ms_t a, logic [31:0] b);
        logic [TIME_WIDTH:0] s;
        s = {1'b0, a} + {{(TIME_WIDTH-31){1'b0}}, b};
        return s[TIME_WIDTH] ? TIME_MAX : s[TIME_WIDTH-1:0];
    endfunction

    function automatic void shut_breaker();
        if (breaker_open)
        begin
            breaker_open = 1'b0;
            release_at = '0;
            ev_flags[EV_CLOSED] = 1'b1;
        end
    endfunction

    function automatic void clear_run();
        awaiting = 1'b0;
        retries = '0;
        attempts = '0;
        backoff = init_backoff;
        due_at = '0;
        reply_ready = 1'b0;
        held = 1'b0;
    endfunction

    function automatic void count_failure(ms_t now);
        logic [32:0] doubled;
        awaiting = 1'b0;
        if (retries != 9'h1FF)
            retries = retries + 9'd1;
        if (attempts != 16'hFFFF)
            attempts = attempts + 16'd1;
        if (retries > {1'b0, retry_limit})
        begin
            // give up and open the breaker
            ev_flags[EV_GIVEUP] = 1'b1;
            if (!breaker_open)
            begin
                breaker_open = 1'b1;
                release_at = sat_add(now, cool_period);
                held = 1'b0;
                due_at = '0;
                ev_flags[EV_OPEN] = 1'b1;
            end
        end
        else
        begin
            if (backoff == 32'd0)
                backoff = min_delay;
            else
            begin
                doubled = {backoff, 1'b0};
                backoff = (doubled > {1'b0, backoff_cap}) ? backoff_cap : doubled[31:0];
            end
            due_at = sat_add(now, backoff);
            ev_flags[EV_RETRY] = 1'b1;
        end
    endfunction

    function automatic status_t try_dispatch(ms_t now, logic [1:0] outcome);
        if (!held || breaker_open || awaiting)
            return ST_BUSY;
        sent = 1'b1;
        if (outcome == OUTCOME_ACCEPTED)
        begin
            awaiting = 1'b1;
            if (attempts != 16'hFFFF)
                attempts = attempts + 16'd1;
            due_at = '0;
            ev_flags[EV_ATTEMPT] = 1'b1;
            return ST_OK;
        end
        if (outcome == OUTCOME_BUSY)
        begin
            due_at = sat_add(now, min_delay);
            backoff = min_delay;
            return ST_BUSY;
        end
        // failed, and the unused outcome code counts as failed too
        count_failure(now);
        return ST_FAIL;
    endfunction

    function automatic res_t supervise(kind_t kind, ms_t now, logic [15:0] len,
                                       logic [1:0] outcome, logic efail, logic [7:0] fcode,
                                       logic resp);
        res_t        r;
        status_t     st;
        logic [7:0]  code;
        logic        taken;
        logic [15:0] cap;
        st = ST_OK;
        code = '0;
        taken = 1'b0;
        ev_flags = '0;
        sent = 1'b0;
        cap = (capacity != 16'd0) ? capacity : DEFAULT_CAPACITY;
        case (kind)
            KIND_SUBMIT:
            begin
                if (len == 16'd0)
                    st = ST_INVALID;
                else
                begin
                    if (breaker_open)
                    begin
                        if (now >= release_at)
                            shut_breaker();
                        else
                            st = ST_BUSY;
                    end
                    if (st == ST_OK)
                    begin
                        if (len > cap)
                            st = ST_NORES;
                        else
                        begin
                            held = 1'b1;
                            retries = '0;
                            attempts = '0;
                            backoff = init_backoff;
                            due_at = '0;
                            reply_ready = 1'b0;
                            st = try_dispatch(now, outcome);
                            if (st == ST_FAIL)
                                code = fcode;
                        end
                    end
                end
            end
            KIND_STEP:
            begin
                if (breaker_open && now >= release_at)
                    shut_breaker();
                if (awaiting)
                begin
                    if (efail)
                    begin
                        st = ST_FAIL;
                        code = fcode;
                        count_failure(now);
                    end
                    // a response still lands after a failure unless the breaker opened
                    if (!breaker_open && resp)
                    begin
                        awaiting = 1'b0;
                        held = 1'b0;
                        reply_ready = 1'b1;
                        retries = '0;
                        backoff = init_backoff;
                        due_at = '0;
                        attempts = '0;
                        ev_flags[EV_RESP] = 1'b1;
                    end
                end
                if (!awaiting && held && !breaker_open && due_at != '0 && now >= due_at)
                    void'(try_dispatch(now, outcome));
            end
            KIND_RESET:
            begin
                shut_breaker();
                clear_run();
            end
            default:
            begin
                if (reply_ready)
                begin
                    reply_ready = 1'b0;
                    taken = 1'b1;
                end
            end
        endcase

        if (breaker_open)
            r.supervisor_state = SUP_OPEN;
        else if (awaiting)
            r.supervisor_state = SUP_WAITING;
        else if (held && due_at != '0)
            r.supervisor_state = SUP_RETRY;
        else if (held)
            r.supervisor_state = SUP_WAITING;
        else
            r.supervisor_state = SUP_IDLE;
        r.status = st;
        r.status_code = code;
        r.event_mask = ev_flags;
        r.send_strobe = sent;
        r.retries_done = retries;
        r.response_taken = taken;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_backoff = RST_INITIAL_BACKOFF;
            max_backoff = RST_MAX_BACKOFF;
            retry_limit = RST_RETRY_LIMIT;
            cool_period = RST_COOLDOWN;
            capacity = RST_CAPACITY;
            breaker_open = 1'b0;
            release_at = '0;
            clear_run();
            predicted_results.delete();
            outstanding <= 0;
            failures <= mismatches;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result beat with no event pending: %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    got = m_tdata[$bits(res_t)-1:0];
                    check_field("status", want.status, got.status);
                    check_field("status_code", want.status_code, got.status_code);
                    check_field("event_mask", want.event_mask, got.event_mask);
                    check_field("send_strobe", want.send_strobe, got.send_strobe);
                    check_field("supervisor_state", want.supervisor_state,
                                got.supervisor_state);
                    check_field("retries_done", want.retries_done, got.retries_done);
                    check_field("response_taken", want.response_taken, got.response_taken);
                end
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_INITIAL_BACKOFF: init_backoff = cfg_data;
                    CFG_MAX_BACKOFF:     max_backoff = cfg_data;
                    CFG_RETRY_LIMIT:     retry_limit = cfg_data[7:0];
                    CFG_COOLDOWN:        cool_period = cfg_data;
                    CFG_CAPACITY:        capacity = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predicted_results.push_back(supervise(kind_t'(s_tuser),
                                                      s_tdata[TIME_WIDTH-1:0],
                                                      s_tdata[TIME_WIDTH +: 16],
                                                      s_tdata[TIME_WIDTH+16 +: 2],
                                                      s_tdata[TIME_WIDTH+18],
                                                      s_tdata[TIME_WIDTH+19 +: 8],
                                                      s_tdata[TIME_WIDTH+27]));
            outstanding <= predicted_results.size();
            failures <= mismatches;
        end
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// top of the retry backoff circuit breaker bench: clock, reset, event stimulus,
// configuration phases and back-pressure; checking lives in rbcb_result_checker
// depends on rbcb_pkg, rbcb_result_checker and the design files
module tb;
    import rbcb_pkg::*;

    localparam int TIME_WIDTH   = TIME_WIDTH_DEFAULT;
    localparam int IN_W         = ((TIME_WIDTH + IN_FIXED_BITS + 7) / 8) * 8;
    localparam int PHASE_ITEMS  = 222;
    localparam int QUIET_ITEMS  = 150;
    localparam logic [1:0] OUTCOME_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    int unsigned           outstanding;
    int unsigned           failures;

    logic [TIME_WIDTH-1:0] clock_ms = 40'd10000;
    int                    cap_hint = 260;
    bit                    gappy = 1'b1;
    bit                    quiet = 1'b0;
    int                    stall_left = 0;

    retry_backoff_circuit_breaker #(.TIME_WIDTH(TIME_WIDTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rbcb_result_checker #(.TIME_WIDTH(TIME_WIDTH)) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .failures    (failures)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side back-pressure in bursts
    always @(negedge clk)
    begin
        if (quiet)
        begin
            m_tready <= 1'b1;
            stall_left = 0;
        end
        else if (stall_left != 0)
            stall_left--;
        else if (!m_tready)
            m_tready <= 1'b1;
        else if (gappy && $urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(1, 12) - 1;
        end
    end

    task automatic send_event(kind_t kind, logic [TIME_WIDTH-1:0] now, logic [15:0] len,
                              logic [1:0] outcome, logic efail, logic [7:0] fcode,
                              logic resp);
        int gap;
        gap = (!quiet && gappy && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
        if (gap != 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= IN_W'({resp, fcode, efail, outcome, len, now});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
    endtask

    task automatic configure(logic [31:0] init_b, logic [31:0] max_b, logic [7:0] limit,
                             logic [31:0] cool, logic [15:0] cap);
        drain();
        write_reg(CFG_INITIAL_BACKOFF, init_b);
        write_reg(CFG_MAX_BACKOFF, max_b);
        write_reg(CFG_RETRY_LIMIT, {24'd0, limit});
        write_reg(CFG_COOLDOWN, cool);
        write_reg(CFG_CAPACITY, {16'd0, cap});
        @(negedge clk);
        cfg_we <= 1'b0;
        cap_hint = (cap == 16'd0) ? DEFAULT_CAPACITY : cap;
    endtask

    task automatic random_event();
        int          pick;
        kind_t       kind;
        logic [15:0] len;
        logic [1:0]  outcome;
        // mostly a forward-running clock, now and then a jump anywhere
        pick = $urandom_range(0, 63);
        if (pick == 0)
            clock_ms = TIME_WIDTH'({$urandom, $urandom});
        else if (pick == 1)
            clock_ms = {TIME_WIDTH{1'b1}} - TIME_WIDTH'($urandom_range(0, 3000));
        else if (pick < 6)
            clock_ms = clock_ms + TIME_WIDTH'($urandom);
        else if (pick < 24)
            clock_ms = clock_ms + TIME_WIDTH'($urandom_range(0, 3000));
        else
            clock_ms = clock_ms + TIME_WIDTH'($urandom_range(0, 200));

        pick = $urandom_range(0, 99);
        if (pick < 25)
            kind = KIND_SUBMIT;
        else if (pick < 80)
            kind = KIND_STEP;
        else if (pick < 85)
            kind = KIND_RESET;
        else
            kind = KIND_TAKE;

        pick = $urandom_range(0, 99);
        if (pick < 3)
            len = 16'd0;
        else if (pick < 13)
            len = 16'($urandom);
        else
            len = 16'($urandom_range(1, cap_hint));

        pick = $urandom_range(0, 19);
        if (pick < 12)
            outcome = OUTCOME_ACCEPTED;
        else if (pick < 15)
            outcome = OUTCOME_BUSY;
        else if (pick < 19)
            outcome = OUTCOME_FAILED;
        else
            outcome = OUTCOME_UNUSED;

        send_event(kind, clock_ms, len, outcome, $urandom_range(0, 5) == 0,
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed pass on reset configuration
        send_event(KIND_SUBMIT, 40'd1000, 16'd0, OUTCOME_ACCEPTED, 1'b0, 8'h00, 1'b0);
        send_event(KIND_SUBMIT, 40'd1000, 16'd261, OUTCOME_ACCEPTED, 1'b0, 8'h00, 1'b0);
        send_event(KIND_TAKE, 40'd1001, 16'd0, OUTCOME_ACCEPTED, 1'b0, 8'h00, 1'b0);
        send_event(KIND_SUBMIT, 40'd1002, 16'd1, OUTCOME_ACCEPTED, 1'b0, 8'h00, 1'b0);
        // replacement while waiting
        send_event(KIND_SUBMIT, 40'd1003, 16'd260, OUTCOME_ACCEPTED, 1'b0, 8'h00, 1'b0);
        send_event(KIND_STEP, 40'd1010, 16'd0, OUTCOME_ACCEPTED, 1'b0, 8'h00, 1'b1);
        send_event(KIND_TAKE, 40'd1011, 16'd0, OUTCOME_ACCEPTED, 1'b0, 8'h00, 1'b0);
        send_event(KIND_TAKE, 40'd1012, 16'd0, OUTCOME_ACCEPTED, 1'b0, 8'h00, 1'b0);
        send_event(KIND_SUBMIT, 40'd1020, 16'd16, OUTCOME_BUSY, 1'b0, 8'h00, 1'b0);
        send_event(KIND_STEP, 40'd1119, 16'd0, OUTCOME_FAILED, 1'b0, 8'h00, 1'b0);
        send_event(KIND_STEP, 40'd1120, 16'd0, OUTCOME_FAILED, 1'b0, 8'h00, 1'b0);
        send_event(KIND_STEP, 40'd1320, 16'd0, OUTCOME_UNUSED, 1'b0, 8'hFF, 1'b0);
        send_event(KIND_STEP, 40'd1720, 16'd0, OUTCOME_ACCEPTED, 1'b0, 8'h00, 1'b0);
        // engine failure with a zero code
        send_event(KIND_STEP, 40'd1721, 16'd0, OUTCOME_ACCEPTED, 1'b1, 8'h00, 1'b0);
        send_event(KIND_STEP, 40'd2521, 16'd0, OUTCOME_ACCEPTED, 1'b0, 8'h00, 1'b0);
        // one failure too many, breaker opens
        send_event(KIND_STEP, 40'd2522, 16'd0, OUTCOME_ACCEPTED, 1'b1, 8'hA5, 1'b0);
        send_event(KIND_SUBMIT, 40'd3000, 16'd8, OUTCOME_ACCEPTED, 1'b0, 8'h00, 1'b0);
        send_event(KIND_STEP, 40'd3522, 16'd0, OUTCOME_ACCEPTED, 1'b0, 8'h00, 1'b0);
        send_event(KIND_SUBMIT, 40'd3600, 16'd5, OUTCOME_FAILED, 1'b0, 8'h5A, 1'b0);
        send_event(KIND_RESET, 40'd3601, 16'd0, OUTCOME_ACCEPTED, 1'b0, 8'h00, 1'b0);
        send_event(KIND_SUBMIT, 40'd3700, 16'd7, OUTCOME_ACCEPTED, 1'b0, 8'h00, 1'b0);
        // failure and response in the same beat
        send_event(KIND_STEP, 40'd3701, 16'd0, OUTCOME_ACCEPTED, 1'b1, 8'h3C, 1'b1);
        send_event(KIND_TAKE, 40'd3702, 16'd0, OUTCOME_ACCEPTED, 1'b0, 8'h00, 1'b0);
        // retry time saturates at the top of the clock range
        send_event(KIND_SUBMIT, 40'hFF_FFFF_FFF0, 16'd3, OUTCOME_BUSY, 1'b0, 8'h00, 1'b0);
        send_event(KIND_STEP, 40'hFF_FFFF_FFFF, 16'd0, OUTCOME_ACCEPTED, 1'b1, 8'hFF, 1'b1);

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: configure(32'd0, 32'd0, 8'd0, 32'd0, 16'd0);
                1: configure(32'd1, 32'hFFFF_FFFF, 8'd255, 32'd5, 16'hFFFF);
                2: configure(32'hFFFF_FFFF, 32'd1, 8'd1, 32'hFFFF_FFFF, 16'd1);
                5: configure(RST_INITIAL_BACKOFF, RST_MAX_BACKOFF, RST_RETRY_LIMIT,
                             RST_COOLDOWN, RST_CAPACITY);
                default: configure($urandom_range(1, 50), $urandom_range(0, 1000),
                                   8'($urandom_range(1, 6)), $urandom_range(0, 500),
                                   16'($urandom_range(1, 300)));
            endcase
            for (int j = 0; j < PHASE_ITEMS; j++)
            begin
                if (j % 40 == 0)
                    gappy = ($urandom_range(0, 3) != 0);
                if (p == 5 && j >= PHASE_ITEMS - QUIET_ITEMS)
                    quiet = 1'b1;
                // hold the sender until everything in flight has come back
                if (j == PHASE_ITEMS / 2 && !quiet)
                    drain();
                random_event();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("PASS retry_backoff_circuit_breaker");
        else
            $display("FAIL retry_backoff_circuit_breaker");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL retry_backoff_circuit_breaker");
        $finish;
    end

endmodule
